[sv/atan2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_pkg: shared types and constants
// Fixed-point formats, polynomial coefficients and the per-beat flag bundle
// that travels down the atan2 pipeline.
// ----------------------------------------------------------------------------
package atan2_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 29;

  // Ratio and coefficient fraction bits.
  localparam int QF    = 30;
  localparam int ACC_W = 33;
  localparam int NCOEF = 6;

  localparam logic signed [31:0] POLY_COEF [NCOEF] = '{
    32'sd1073717407, -32'sd357151731, 32'sd207815708,
    -32'sd125018842, 32'sd56536072, -32'sd12585543
  };

  // Pi in Q.60.
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;

  typedef struct packed {
    logic x_neg;
    logic x_zero;
    logic y_neg;
    logic y_zero;
    logic swap;    // |y| > |x|, ratio taken as |x| / |y|
    logic ge;      // numerator equals denominator, ratio is one
  } atan2_ctl_t;

endpackage

[sv/atan2_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_div: pipelined restoring divider
// Produces a QF-bit fraction num/den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module atan2_div #(
  parameter int MAG_W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic [MAG_W-1:0]       num_i,
  input  logic [MAG_W-1:0]       den_i,
  input  atan2_pkg::atan2_ctl_t  ctl_i,
  output logic                   valid_o,
  output logic [atan2_pkg::QF-1:0] quot_o,
  output atan2_pkg::atan2_ctl_t  ctl_o
);
  import atan2_pkg::*;

  localparam int REM_W = MAG_W + 1;

  logic [REM_W-1:0] rem_q  [QF];
  logic [QF-1:0]    quot_q [QF];
  logic [MAG_W-1:0] den_q  [QF];
  atan2_ctl_t       ctl_q  [QF];
  logic [QF-1:0]    v_q;

  for (genvar i = 0; i < QF; i++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [QF-1:0]    quot_in;
    logic [MAG_W-1:0] den_in;
    atan2_ctl_t       ctl_in;
    logic             v_in;
    logic [REM_W-1:0] rem_sh;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in  = REM_W'(num_i);
      assign quot_in = '0;
      assign den_in  = den_i;
      assign ctl_in  = ctl_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign quot_in = quot_q[i-1];
      assign den_in  = den_q[i-1];
      assign ctl_in  = ctl_q[i-1];
      assign v_in    = v_q[i-1];
    end

    assign rem_sh = {rem_in[REM_W-2:0], 1'b0};
    assign take   = (rem_sh >= REM_W'(den_in));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= take ? (rem_sh - REM_W'(den_in)) : rem_sh;
        quot_q[i] <= {quot_in[QF-2:0], take};
        den_q[i]  <= den_in;
        ctl_q[i]  <= ctl_in;
      end
    end
  end

  assign valid_o = v_q[QF-1];
  assign quot_o  = quot_q[QF-1];
  assign ctl_o   = ctl_q[QF-1];

endmodule

[sv/atan2_polynomial_approx.sv]
`timescale 1ns / 1ps
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds only while a finished result is stalled at the output register.
// The 30-stage divider (one quotient bit per stage) sets most of the latency.
// Reset clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// atan2_polynomial_approx: four-quadrant arctangent
// Computes atan2(y, x) in signed Q2.(ANGLE_FRAC_BITS) radians from an odd
// 11th-order polynomial in the octant ratio, with quadrant correction.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx #(
  parameter int COORD_WIDTH     = atan2_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = atan2_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]       x_coord_i,
  input  logic signed [COORD_WIDTH-1:0]       y_coord_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ANGLE_FRAC_BITS+2:0]   angle_o
);
  import atan2_pkg::*;

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int RSH     = 60 - ANGLE_FRAC_BITS;
  localparam int NSTEP   = 7;   // square, five Horner steps, final multiply
  localparam int T_W     = QF + 1;

  // The whole pipeline moves as one shift register. It stops only when the
  // output register holds a beat that the consumer is stalling.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes, signs and octant selection.
  // The magnitude of the most negative coordinate is exact in COORD_WIDTH
  // unsigned bits.
  // --------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] ax, ay;
  atan2_ctl_t             ctl_d;

  assign ax = x_coord_i[COORD_WIDTH-1] ? (~x_coord_i + 1'b1) : x_coord_i;
  assign ay = y_coord_i[COORD_WIDTH-1] ? (~y_coord_i + 1'b1) : y_coord_i;

  always_comb begin
    ctl_d.x_neg  = x_coord_i[COORD_WIDTH-1];
    ctl_d.y_neg  = y_coord_i[COORD_WIDTH-1];
    ctl_d.x_zero = (x_coord_i == '0);
    ctl_d.y_zero = (y_coord_i == '0);
    ctl_d.swap   = (ay > ax);
    ctl_d.ge     = (ay == ax);
  end

  logic                   s1_v_q;
  logic [COORD_WIDTH-1:0] s1_num_q, s1_den_q;
  atan2_ctl_t             s1_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_num_q <= ctl_d.swap ? ax : ay;
      s1_den_q <= ctl_d.swap ? ay : ax;
      s1_ctl_q <= ctl_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: ratio r = min / max in Q.30. A zero denominator only occurs at
  // the origin, whose angle does not use the ratio.
  // --------------------------------------------------------------------------
  logic          dv_v;
  logic [QF-1:0] dv_quot;
  atan2_ctl_t    dv_ctl;

  atan2_div #(
    .MAG_W (COORD_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_v_q),
    .num_i   (s1_num_q),
    .den_i   (s1_den_q),
    .ctl_i   (s1_ctl_q),
    .valid_o (dv_v),
    .quot_o  (dv_quot),
    .ctl_o   (dv_ctl)
  );

  // --------------------------------------------------------------------------
  // Multiply pipeline. Each step is two stages: an unsigned magnitude product,
  // then rounding to Q.30 (ties away from zero), the sign and the Horner add.
  // Step 0 forms u = r*r, steps 1 to 5 run Horner's rule in u, and step 6
  // multiplies by r to finish the odd polynomial.
  // --------------------------------------------------------------------------
  logic                    mv_q   [NSTEP];
  logic [63:0]             mp_q   [NSTEP];
  logic                    mneg_q [NSTEP];
  logic [T_W-1:0]          mt_q   [NSTEP];
  logic [T_W-1:0]          mu_q   [NSTEP];
  atan2_ctl_t              mctl_q [NSTEP];

  logic                    rv_q   [NSTEP];
  logic [T_W-1:0]          rt_q   [NSTEP];
  logic [T_W-1:0]          ru_q   [NSTEP];
  logic signed [ACC_W-1:0] racc_q [NSTEP];
  atan2_ctl_t              rctl_q [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_mac
    logic                    v_in;
    logic [T_W-1:0]          t_in, u_in;
    logic signed [ACC_W-1:0] acc_in;
    atan2_ctl_t              ctl_in;
    logic [31:0]             opa;
    logic [T_W-1:0]          opb;
    logic [33:0]             rnd;
    logic signed [ACC_W-1:0] prod_s;
    logic signed [ACC_W-1:0] addend;

    if (j == 0) begin : g_first
      assign v_in   = dv_v;
      assign t_in   = dv_ctl.ge ? T_W'(1) << QF : T_W'(dv_quot);
      assign u_in   = '0;
      assign acc_in = ACC_W'(POLY_COEF[NCOEF-1]);
      assign ctl_in = dv_ctl;
      assign opa    = 32'(t_in);
      assign opb    = t_in;
    end else begin : g_next
      assign v_in   = rv_q[j-1];
      assign t_in   = rt_q[j-1];
      assign u_in   = ru_q[j-1];
      assign acc_in = racc_q[j-1];
      assign ctl_in = rctl_q[j-1];
      assign opa    = acc_in[ACC_W-1] ? 32'(-acc_in) : 32'(acc_in);
      assign opb    = (j == NSTEP - 1) ? t_in : u_in;
    end

    if (j >= 1 && j <= NCOEF - 1) begin : g_add
      assign addend = ACC_W'(POLY_COEF[NCOEF-1-j]);
    end else begin : g_noadd
      assign addend = '0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[j] <= 1'b0;
        rv_q[j] <= 1'b0;
      end else if (adv) begin
        mv_q[j] <= v_in;
        rv_q[j] <= mv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mp_q[j]   <= 64'(opa) * 64'(opb);
        mneg_q[j] <= (j != 0) && acc_in[ACC_W-1];
        mt_q[j]   <= t_in;
        mu_q[j]   <= u_in;
        mctl_q[j] <= ctl_in;
      end
    end

    assign rnd    = 34'((mp_q[j] + (64'd1 << (QF - 1))) >> QF);
    assign prod_s = mneg_q[j] ? -ACC_W'(rnd) : ACC_W'(rnd);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_q[j]   <= mt_q[j];
        rctl_q[j] <= mctl_q[j];
        if (j == 0) begin
          ru_q[j]   <= T_W'(rnd);
          racc_q[j] <= ACC_W'(POLY_COEF[NCOEF-1]);
        end else begin
          ru_q[j]   <= mu_q[j];
          racc_q[j] <= prod_s + addend;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Combine: octant angle in Q.60, reflection about pi/4 when the ratio was
  // swapped, axis cases and quadrant correction.
  // --------------------------------------------------------------------------
  logic                    fv;
  logic signed [ACC_W-1:0] facc;
  atan2_ctl_t              fctl;
  logic [63:0]             oct, theta, theta_c, mag_d;

  assign fv   = rv_q[NSTEP-1];
  assign facc = racc_q[NSTEP-1];
  assign fctl = rctl_q[NSTEP-1];

  always_comb begin
    // A negative polynomial value is clamped to zero.
    oct = facc[ACC_W-1] ? '0 : (64'(facc) << (60 - QF));
    if (fctl.x_zero) begin
      theta = HALF_PI_Q60;
    end else if (!fctl.swap) begin
      theta = oct;
    end else begin
      theta = HALF_PI_Q60 - oct;
    end
    theta_c = (theta > HALF_PI_Q60) ? HALF_PI_Q60 : theta;
    if (!fctl.x_neg) begin
      mag_d = theta_c;
    end else if (fctl.y_zero) begin
      mag_d = PI_Q60;
    end else begin
      mag_d = PI_Q60 - theta_c;
    end
  end

  logic        cb_v_q;
  logic [63:0] cb_mag_q;
  atan2_ctl_t  cb_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_v_q <= 1'b0;
    end else if (adv) begin
      cb_v_q <= fv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cb_mag_q <= mag_d;
      cb_ctl_q <= fctl;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round the magnitude to nearest (ties upward), then apply
  // the sign so that the result is symmetric. The origin gives zero.
  // --------------------------------------------------------------------------
  logic [63:0]        rmag;
  logic [ANGLE_W-1:0] angle_d;
  logic               out_v_q;
  logic [ANGLE_W-1:0] angle_q;
  atan2_ctl_t         out_ctl_q;

  assign rmag = (cb_mag_q + (64'd1 << (RSH - 1))) >> RSH;

  always_comb begin
    if (cb_ctl_q.x_zero && cb_ctl_q.y_zero) begin
      angle_d = '0;
    end else if (cb_ctl_q.y_neg) begin
      angle_d = -ANGLE_W'(rmag);
    end else begin
      angle_d = ANGLE_W'(rmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= cb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q   <= angle_d;
      out_ctl_q <= cb_ctl_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign angle_o     = angle_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The input side is held back exactly when a result beat is stuck.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the output register");

  // The origin always produces a zero angle.
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ctl_q.x_zero && out_ctl_q.y_zero |-> angle_o == '0)
    else $error("nonzero angle at the origin");

  // The upper half-plane never yields a negative angle.
  a_upper_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ctl_q.y_neg |-> !angle_o[ANGLE_W-1])
    else $error("negative angle for a nonnegative y coordinate");

endmodule
